/* rtl/assert_macros.svh */
// Assertion helpers for the RTL top. Each macro expects clk and arst_n in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define ASSERT_IMPL(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("%m: implication check failed");

// Next-cycle implication, checked outside reset.
`define ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("%m: next-cycle check failed");

`endif

/* rtl/gtsr_pkg.sv */
package gtsr_pkg;

	localparam int MAX_ORDER = 64;
	localparam int WORD_W    = 64;
	localparam int IDX_W     = 6;
	localparam int ORDER_W   = 7;
	localparam int CFG_IDX_W = 1;
	localparam int CFG_VAL_W = 7;

	localparam logic CMD_LOAD  = 1'b0;
	localparam logic CMD_SOLVE = 1'b1;

	localparam logic MODE_UPPER = 1'b0;
	localparam logic MODE_LOWER = 1'b1;

	localparam logic [CFG_IDX_W-1:0] REG_MODE  = CFG_IDX_W'(0);
	localparam logic [CFG_IDX_W-1:0] REG_ORDER = CFG_IDX_W'(1);

	typedef struct packed {
		logic              valid;
		logic [WORD_W-1:0] data;
	} pipe_t;

	typedef struct packed {
		logic [WORD_W-1:0] mask;
		logic [WORD_W-1:0] bit_sel;
	} stage_ctl_t;

	// Bits 0 .. n-1 set.
	function automatic logic [WORD_W-1:0] below_mask(int n);
		logic [WORD_W-1:0] m;
		m = '0;
		for (int k = 0; k < WORD_W; k++) begin
			m[k] = (k < n);
		end
		return m;
	endfunction

	function automatic logic [WORD_W-1:0] one_hot(int c);
		logic [WORD_W-1:0] m;
		m = '0;
		for (int k = 0; k < WORD_W; k++) begin
			m[k] = (k == c);
		end
		return m;
	endfunction

endpackage

/* rtl/gtsr_store.sv */
module gtsr_store
	import gtsr_pkg::*;
(
	input  logic              clk,
	input  logic              wr_en,
	input  logic [IDX_W-1:0]  wr_idx,
	input  logic [WORD_W-1:0] wr_data,
	output logic [WORD_W-1:0] rows [MAX_ORDER]
);

	logic [WORD_W-1:0] rows_q [MAX_ORDER];

	// Rows hold no reset; a row is meaningful once it has been loaded.
	always_ff @(posedge clk) begin
		if (wr_en) begin
			rows_q[wr_idx[$clog2(MAX_ORDER)-1:0]] <= wr_data;
		end
	end

	assign rows = rows_q;

endmodule

/* rtl/gtsr_stage.sv */
module gtsr_stage
	import gtsr_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              adv,
	input  pipe_t             word_in,
	input  logic [WORD_W-1:0] col,
	input  stage_ctl_t        ctl,
	output pipe_t             word_out
);

	logic              valid_s1;
	logic [WORD_W-1:0] data_s1;
	logic              par;
	logic [WORD_W-1:0] data_next;

	// Parity of the already solved bits that the column touches decides the flip.
	assign par       = ^(word_in.data & col & ctl.mask);
	assign data_next = word_in.data ^ (ctl.bit_sel & {WORD_W{par}});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (adv) begin
			valid_s1 <= word_in.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			data_s1 <= data_next;
		end
	end

	assign word_out.valid = valid_s1;
	assign word_out.data  = data_s1;

endmodule

/* rtl/gf2_triangular_solve_right.sv */
// Right-side unit triangular solve over GF(2): for each right-hand word b the
// block returns x with x * T = b. T is held in a row store of MAX_ORDER rows.
// Input channel (in_valid/in_ready): command, row_index, row_data. A load word
// writes row row_index of T and produces no output; a solve word produces one
// solution_row on the output channel (out_valid/out_ready).
// Configuration channel (cfg_valid/cfg_ready, always ready): index 0 selects
// upper (ascending) or lower (descending) mode, index 1 sets the order, which
// saturates at MAX_ORDER. Configure only while the block is idle.
// Pipeline: MAX_ORDER stages, one column of T per stage. A solve word passes
// through every stage whatever the order and is held on the output until
// taken. Throughput: one solve word per cycle while the output is not stalled.
// A load word is taken only when no solve is in flight, so a load behind
// solves waits until the pipeline has drained; this keeps every solve on the
// matrix it was issued to.
// When the receiver stalls, the whole pipeline holds and nothing is lost.
// Reset clears all stage valid bits, sets upper mode and an order of 64; the
// row store is not cleared and must be loaded before it is used.
module gf2_triangular_solve_right
	import gtsr_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [CFG_VAL_W-1:0] cfg_value,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  logic                 command,
	input  logic [IDX_W-1:0]     row_index,
	input  logic [WORD_W-1:0]    row_data,
	output logic                 out_valid,
	input  logic                 out_ready,
	output logic [WORD_W-1:0]    solution_row
);

	`include "assert_macros.svh"

	logic               mode_q;
	logic [ORDER_W-1:0] order_q;
	logic [WORD_W-1:0]  lt_n;
	logic [WORD_W-1:0]  rows [MAX_ORDER];
	logic [WORD_W-1:0]  cols [MAX_ORDER];
	pipe_t              head;
	pipe_t              stage_out [MAX_ORDER];
	logic [MAX_ORDER-1:0] valid_vec;
	logic               adv;
	logic               busy;
	logic               in_acc;
	logic               store_wr;

	// Configuration registers. The order is stored already saturated.
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q  <= MODE_UPPER;
			order_q <= ORDER_W'(MAX_ORDER);
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				REG_MODE:  mode_q <= cfg_value[0];
				REG_ORDER: begin
					if (ORDER_W'(cfg_value) > ORDER_W'(MAX_ORDER)) begin
						order_q <= ORDER_W'(MAX_ORDER);
					end else begin
						order_q <= ORDER_W'(cfg_value);
					end
				end
				default: ;
			endcase
		end
	end

	// Rows below the order; bounds the lower-mode column windows.
	always_comb begin
		for (int k = 0; k < WORD_W; k++) begin
			lt_n[k] = (ORDER_W'(k) < order_q);
		end
	end

	// The whole pipeline moves together; it halts only on an output stall.
	assign adv      = !out_valid || out_ready;
	assign busy     = |valid_vec;
	assign in_ready = (command == CMD_SOLVE) ? adv : !busy;
	assign in_acc   = in_valid && in_ready;
	assign store_wr = in_acc && (command == CMD_LOAD) &&
		({1'b0, row_index} < ORDER_W'(MAX_ORDER));

	gtsr_store u_store (
		.clk     (clk),
		.wr_en   (store_wr),
		.wr_idx  (row_index),
		.wr_data (row_data),
		.rows    (rows)
	);

	// Column c of T gathered with bit k = T[k][c].
	for (genvar c = 0; c < MAX_ORDER; c++) begin : g_col
		for (genvar k = 0; k < WORD_W; k++) begin : g_bit
			if (k < MAX_ORDER) begin : g_row
				assign cols[c][k] = rows[k][c];
			end else begin : g_pad
				assign cols[c][k] = 1'b0;
			end
		end
	end

	assign head.valid = in_acc && (command == CMD_SOLVE);
	assign head.data  = row_data;

	// Stage j handles column j in upper mode and column MAX_ORDER-1-j in lower
	// mode, so both modes visit their columns in the required order.
	for (genvar j = 0; j < MAX_ORDER; j++) begin : g_stage
		localparam int UC = j;
		localparam int LC = MAX_ORDER - 1 - j;

		logic              up_active;
		logic              lo_active;
		logic [WORD_W-1:0] col;
		stage_ctl_t        ctl;
		pipe_t             word_in;

		assign up_active = (UC != 0) && (ORDER_W'(UC) < order_q);
		assign lo_active = ORDER_W'(LC + 1) < order_q;

		always_comb begin
			if (mode_q == MODE_LOWER) begin
				col         = cols[LC];
				ctl.mask    = ~below_mask(LC + 1) & lt_n;
				ctl.bit_sel = lo_active ? one_hot(LC) : '0;
			end else begin
				col         = cols[UC];
				ctl.mask    = below_mask(UC);
				ctl.bit_sel = up_active ? one_hot(UC) : '0;
			end
		end

		if (j == 0) begin : g_first
			assign word_in = head;
		end else begin : g_next
			assign word_in = stage_out[j-1];
		end

		gtsr_stage u_stage (
			.clk      (clk),
			.arst_n   (arst_n),
			.adv      (adv),
			.word_in  (word_in),
			.col      (col),
			.ctl      (ctl),
			.word_out (stage_out[j])
		);

		assign valid_vec[j] = stage_out[j].valid;
	end

	assign out_valid    = stage_out[MAX_ORDER-1].valid;
	assign solution_row = stage_out[MAX_ORDER-1].data;

	// A load must never overtake a solve that is still reading the store.
	`ASSERT_IMPL(a_load_when_empty, in_acc && (command == CMD_LOAD), !busy)
	// A held pipeline keeps every valid bit where it was.
	`ASSERT_NEXT(a_stall_holds, !adv, $stable(valid_vec))
	// An accepted solve enters the first stage on the next edge.
	`ASSERT_NEXT(a_solve_enters, in_acc && (command == CMD_SOLVE), valid_vec[0])

endmodule

/* sim/gtsr_checker.sv */
// Scoreboard for the GF(2) triangular solver. It watches all three channels,
// keeps its own copy of the row store and the two registers, and predicts
// the solution of every solve word at the edge where that word is accepted.
module gtsr_checker
	import gtsr_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_valid,
	input  logic                 cfg_ready,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [CFG_VAL_W-1:0] cfg_value,
	input  logic                 in_valid,
	input  logic                 in_ready,
	input  logic                 command,
	input  logic [IDX_W-1:0]     row_index,
	input  logic [WORD_W-1:0]    row_data,
	input  logic                 out_valid,
	input  logic                 out_ready,
	input  logic [WORD_W-1:0]    solution_row,
	output int                   fail_count,
	output int                   pending
);

	logic [WORD_W-1:0]  tri_rows [MAX_ORDER];
	logic               mode_q;
	logic [ORDER_W-1:0] order_q;
	logic [WORD_W-1:0]  expected_rows [$];
	logic [WORD_W-1:0]  want;
	int                 reported;

	// Substitution over the active columns; each solved bit feeds the later ones.
	function automatic logic [WORD_W-1:0] substitute(input logic [WORD_W-1:0] b);
		logic [WORD_W-1:0] x;
		logic [WORD_W-1:0] col;
		int                n;
		x = b;
		n = (order_q > MAX_ORDER) ? MAX_ORDER : int'(order_q);
		if (n < 2) begin
			return x;
		end
		if (mode_q == MODE_UPPER) begin
			for (int i = 1; i < n; i++) begin
				col = '0;
				for (int k = 0; k < i; k++) begin
					col[k] = tri_rows[k][i];
				end
				x[i] = x[i] ^ (^(x & col));
			end
		end else begin
			for (int i = n - 1; i >= 0; i--) begin
				col = '0;
				for (int k = i + 1; k < n; k++) begin
					col[k] = tri_rows[k][i];
				end
				x[i] = x[i] ^ (^(x & col));
			end
		end
		return x;
	endfunction

	initial begin
		fail_count = 0;
		pending    = 0;
		reported   = 0;
	end

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			expected_rows.delete();
			mode_q     = MODE_UPPER;
			order_q    = ORDER_W'(MAX_ORDER);
			fail_count = 0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				if (cfg_index == REG_MODE) begin
					mode_q = cfg_value[0];
				end else if (cfg_index == REG_ORDER) begin
					order_q = cfg_value[ORDER_W-1:0];
				end
			end
			if (out_valid && out_ready) begin
				if (expected_rows.size() == 0) begin
					fail_count++;
					if (reported < 40) begin
						$display("%0t: solution_row expected nothing got %h", $time,
							solution_row);
					end
					reported++;
				end else begin
					want = expected_rows.pop_front();
					if (want !== solution_row) begin
						fail_count++;
						if (reported < 40) begin
							$display("%0t: solution_row expected %h got %h", $time, want,
								solution_row);
						end
						reported++;
					end
				end
			end
			if (in_valid && in_ready) begin
				if (command == CMD_LOAD) begin
					tri_rows[row_index] = row_data;
				end else begin
					expected_rows.push_back(substitute(row_data));
				end
			end
		end
		pending = expected_rows.size();
	end

endmodule

/* sim/tb.sv */
// Testbench top for the GF(2) right-side triangular solver. This module only
// makes stimulus and gives the verdict; all prediction and comparison lives
// in gtsr_checker, which sits beside the block and watches its channels.
module tb;
	import gtsr_pkg::*;

	logic                 clk;
	logic                 arst_n;
	logic                 cfg_valid;
	logic                 cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [CFG_VAL_W-1:0] cfg_value;
	logic                 in_valid;
	logic                 in_ready;
	logic                 command;
	logic [IDX_W-1:0]     row_index;
	logic [WORD_W-1:0]    row_data;
	logic                 out_valid;
	logic                 out_ready;
	logic [WORD_W-1:0]    solution_row;

	int fail_count;
	int pending;

	// Idle rates in percent of cycles, changed by the stimulus per phase.
	int send_idle_pct;
	int recv_idle_pct;
	// Raised once by the stimulus to ask the receiver for a long hold-off.
	bit pressure_go;

	int n_loads;
	int n_solves;
	int n_settings;

	gf2_triangular_solve_right u_dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_valid   (cfg_valid),
		.cfg_ready   (cfg_ready),
		.cfg_index   (cfg_index),
		.cfg_value   (cfg_value),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.command     (command),
		.row_index   (row_index),
		.row_data    (row_data),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.solution_row(solution_row)
	);

	gtsr_checker u_checker (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_valid   (cfg_valid),
		.cfg_ready   (cfg_ready),
		.cfg_index   (cfg_index),
		.cfg_value   (cfg_value),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.command     (command),
		.row_index   (row_index),
		.row_data    (row_data),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.solution_row(solution_row),
		.fail_count  (fail_count),
		.pending     (pending)
	);

	initial begin
		clk = 1'b0;
		forever begin
			#5 clk = ~clk;
		end
	end

	// Hard stop. The limit allows for every load waiting out a full pipeline
	// drain under heavy stalls.
	initial begin
		#(10 * 2_000_000);
		$display("gf2_triangular_solve_right: mismatch");
		$finish;
	end

	// Receiver. It drops out_ready at random at the current rate, and once, when
	// asked, holds it low for a long stretch so that the pipeline fills up and
	// the block has to stall its input while the sender keeps offering words.
	initial begin
		int hold_left;
		bit pressure_done;
		hold_left     = 0;
		pressure_done = 1'b0;
		out_ready     = 1'b0;
		forever begin
			@(negedge clk);
			if (pressure_go && !pressure_done) begin
				pressure_done = 1'b1;
				hold_left     = 500;
			end
			if (hold_left > 0) begin
				hold_left--;
				out_ready = 1'b0;
			end else begin
				out_ready = ($urandom_range(0, 99) >= recv_idle_pct);
			end
		end
	end

	// A test word of a given shape. Shapes: 0 random, 1 all zero, 2 all ones,
	// 3 a single set bit, 4 sparse, 5 dense.
	function automatic logic [WORD_W-1:0] shaped_word(input int shape);
		logic [WORD_W-1:0] w;
		w = {$urandom, $urandom};
		case (shape)
			1: w = '0;
			2: w = '1;
			3: w = WORD_W'(1) << $urandom_range(0, WORD_W - 1);
			4: w = w & {$urandom, $urandom} & {$urandom, $urandom};
			5: w = w | {$urandom, $urandom};
			default: ;
		endcase
		return w;
	endfunction

	// Offers one input word and returns at the edge where it is accepted. Valid
	// is only lowered for an idle cycle, so back-to-back words keep it high.
	task automatic send_word(input logic cmd, input logic [IDX_W-1:0] idx,
		input logic [WORD_W-1:0] data);
		@(negedge clk);
		while ($urandom_range(0, 99) < send_idle_pct) begin
			in_valid = 1'b0;
			@(negedge clk);
		end
		in_valid  = 1'b1;
		command   = cmd;
		row_index = idx;
		row_data  = data;
		do begin
			@(posedge clk);
		end while (!in_ready);
		if (cmd == CMD_LOAD) begin
			n_loads++;
		end else begin
			n_solves++;
		end
	endtask

	// Brings the block to rest: every expected solution has arrived, and then
	// a further pipeline drain has passed so that a trailing load is done.
	task automatic settle();
		@(negedge clk);
		in_valid = 1'b0;
		while (pending != 0) begin
			@(negedge clk);
		end
		repeat (MAX_ORDER + 8) @(negedge clk);
	endtask

	// Writes one register; called at a falling edge and returns at one, with
	// cfg_valid still high so that a following write keeps it asserted.
	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
		input logic [CFG_VAL_W-1:0] value);
		cfg_valid = 1'b1;
		cfg_index = idx;
		cfg_value = value;
		do begin
			@(posedge clk);
		end while (!cfg_ready);
		@(negedge clk);
	endtask

	initial begin
		logic              step_mode;
		int                step_order;
		int                step_items;
		int                burst;
		logic [IDX_W-1:0]  burst_row;

		arst_n        = 1'b0;
		cfg_valid     = 1'b0;
		cfg_index     = '0;
		cfg_value     = '0;
		in_valid      = 1'b0;
		command       = CMD_LOAD;
		row_index     = '0;
		row_data      = '0;
		send_idle_pct = 6;
		recv_idle_pct = 63;
		pressure_go   = 1'b0;
		n_loads       = 0;
		n_solves      = 0;
		n_settings    = 1;

		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// The store is undefined until written, so every row is filled before
		// the first solve. Rows 0 and 63 start at the two extremes of the data.
		for (int r = 0; r < MAX_ORDER; r++) begin
			if (r == 0) begin
				send_word(CMD_LOAD, IDX_W'(r), '1);
			end else if (r == MAX_ORDER - 1) begin
				send_word(CMD_LOAD, IDX_W'(r), '0);
			end else begin
				send_word(CMD_LOAD, IDX_W'(r), shaped_word($urandom_range(0, 5)));
			end
		end

		// Directed words under the reset setting (upper mode, full order): the
		// extreme right-hand rows, single bits at both ends, alternating
		// patterns, and loads interleaved with solves so that each load has to
		// wait for the pipeline to drain.
		send_word(CMD_SOLVE, '0, '0);
		send_word(CMD_SOLVE, '1, '1);
		send_word(CMD_SOLVE, '0, WORD_W'(1));
		send_word(CMD_SOLVE, '1, WORD_W'(1) << (WORD_W - 1));
		send_word(CMD_SOLVE, '0, {WORD_W/4{4'h5}});
		send_word(CMD_SOLVE, '1, {WORD_W/4{4'hA}});
		send_word(CMD_LOAD, IDX_W'(MAX_ORDER - 1), '1);
		send_word(CMD_SOLVE, '0, '1);
		send_word(CMD_SOLVE, '0, WORD_W'(1) << (WORD_W - 1));
		send_word(CMD_LOAD, '0, '0);
		send_word(CMD_SOLVE, '0, '1);
		send_word(CMD_LOAD, IDX_W'(31), WORD_W'(1) << (WORD_W - 1));
		send_word(CMD_SOLVE, '0, WORD_W'(1) << 31);
		send_word(CMD_SOLVE, '1, shaped_word(0));
		send_word(CMD_LOAD, '0, '1);
		send_word(CMD_SOLVE, '0, WORD_W'(1));
		send_word(CMD_SOLVE, '0, shaped_word(0));
		send_word(CMD_SOLVE, '1, shaped_word(5));

		// Random phases, each with its own mode and order. The order goes through
		// zero, one and two, full size, and values above the maximum, which the
		// block saturates. The idle profile changes after steps 4 and 9.
		for (int step = 0; step < 14; step++) begin
			case (step)
				0:  begin step_mode = MODE_UPPER; step_order = 64;  step_items = 200; end
				1:  begin step_mode = MODE_LOWER; step_order = 64;  step_items = 200; end
				2:  begin step_mode = MODE_UPPER; step_order = 1;   step_items = 40;  end
				3:  begin step_mode = MODE_LOWER; step_order = 1;   step_items = 40;  end
				4:  begin step_mode = MODE_UPPER; step_order = 2;   step_items = 60;  end
				5:  begin step_mode = MODE_LOWER; step_order = 2;   step_items = 60;  end
				6:  begin step_mode = MODE_UPPER; step_order = 0;   step_items = 30;  end
				7:  begin step_mode = MODE_LOWER; step_order = 127; step_items = 80;  end
				8:  begin step_mode = MODE_UPPER; step_order = 65;  step_items = 60;  end
				9:  begin
					step_mode  = MODE_LOWER;
					step_order = $urandom_range(3, 63);
					step_items = 150;
				end
				10: begin
					step_mode  = MODE_UPPER;
					step_order = $urandom_range(2, 64);
					step_items = 150;
				end
				11: begin step_mode = MODE_LOWER; step_order = 33;  step_items = 100; end
				12: begin step_mode = MODE_UPPER; step_order = 64;  step_items = 50;  end
				default: begin
					step_mode  = MODE_LOWER;
					step_order = 64;
					step_items = 180;
				end
			endcase

			if (step == 5) begin
				send_idle_pct = 63;
				recv_idle_pct = 6;
			end else if (step == 10) begin
				send_idle_pct = 0;
				recv_idle_pct = 0;
			end

			// Registers change only while the block is at rest. The mode word
			// carries random upper bits, which the block ignores.
			settle();
			write_reg(REG_MODE, {(CFG_VAL_W-1)'($urandom), step_mode});
			write_reg(REG_ORDER, CFG_VAL_W'(step_order));
			cfg_valid = 1'b0;
			n_settings++;

			// With neither side idling, the receiver now stops for a long
			// stretch while this phase keeps offering solve words.
			if (step == 10) begin
				pressure_go = 1'b1;
			end

			// Mostly solves with random content; now and then a single row is
			// reloaded, and rarely a short run of consecutive rows.
			for (int n = 0; n < step_items; n++) begin
				if ($urandom_range(0, 99) < 2) begin
					burst_row = IDX_W'($urandom_range(0, MAX_ORDER - 1));
					for (burst = 0; burst < 4; burst++) begin
						send_word(CMD_LOAD, burst_row + IDX_W'(burst),
							shaped_word($urandom_range(0, 5)));
					end
				end else if ($urandom_range(0, 99) < 6) begin
					send_word(CMD_LOAD, IDX_W'($urandom),
						shaped_word($urandom_range(0, 5)));
				end else if ($urandom_range(0, 99) < 80) begin
					send_word(CMD_SOLVE, IDX_W'($urandom), shaped_word(0));
				end else begin
					send_word(CMD_SOLVE, IDX_W'($urandom), shaped_word($urandom_range(1, 5)));
				end
			end
		end

		// Drain: wait for every outstanding solution, then a further pipeline drain
		// so that a stray word from the block would be seen.
		settle();

		$display("Run covered %0d solve words and %0d row loads over %0d register settings,",
			n_solves, n_loads, n_settings);
		$display("both modes, orders 0, 1, 2, mid-range, 64 and saturated, with a full stall.");
		if (fail_count == 0 && pending == 0) begin
			$display("gf2_triangular_solve_right: match");
		end else begin
			$display("gf2_triangular_solve_right: mismatch");
		end
		$finish;
	end

endmodule

/* filelist.f */
+incdir+rtl
rtl/gtsr_pkg.sv
rtl/gtsr_store.sv
rtl/gtsr_stage.sv
rtl/gf2_triangular_solve_right.sv
sim/gtsr_checker.sv
sim/tb.sv
